// ===== src/qtcrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qtcrt_pkg
// Shared types, register indexes, event codes and helpers of the quadtree
// cell run tracker.
// ----------------------------------------------------------------------------
package qtcrt_pkg;

	localparam int MAX_LEVELS_DEF = 8;
	localparam int INDEX_BITS_DEF = 48;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAF_SIZE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TREE_LEVELS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_GAP_LIMIT = 3'd4;

	localparam logic [31:0] RST_BOX_MIN_X     = 32'd0;
	localparam logic [31:0] RST_BOX_MIN_Y     = 32'd0;
	localparam logic [30:0] RST_LEAF_SIZE     = 31'd1;
	localparam logic [3:0]  RST_TREE_LEVELS   = 4'd0;
	localparam logic [31:0] RST_RUN_GAP_LIMIT = 32'd1000;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [1:0] EV_NEW_CELL  = 2'd0;
	localparam logic [1:0] EV_EXTENDED  = 2'd1;
	localparam logic [1:0] EV_REOPENED  = 2'd2;
	localparam logic [1:0] EV_READ_REPLY = 2'd3;

	typedef struct packed {
		logic               command;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic [47:0]        point_number;
		logic [15:0]        leaf_select;
	} in_item_t;

	typedef struct packed {
		logic [16:0] cell_number;
		logic [1:0]  event_kind;
		logic        cell_present;
		logic [47:0] closed_start;
		logic [47:0] closed_end;
		logic [47:0] open_start;
		logic [47:0] open_end;
		logic [47:0] points_in_cell;
	} out_item_t;

	// (4^lv - 1) / 3 as a sum of powers of four, kept to 17 bits
	function automatic logic [16:0] depth_cell_base(input logic [3:0] lv);
		logic [31:0] acc;
		acc = 32'd0;
		for (int i = 0; i < 16; i++) begin
			if (4'(i) < lv) begin
				acc = acc + (32'd1 << (2 * i));
			end
		end
		return acc[16:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/quadtree_cell_run_tracker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadtree_cell_run_tracker_top
// Maps points to quadtree leaf cells and tracks each cell's count and run.
// ----------------------------------------------------------------------------
// One item is in work at a time. An add command passes a step that checks each
// offset's sign and bound, MAX_LEVELS steps of a one-bit-per-cycle divider
// (both axes side by side) that turns the offsets into leaf column and row, a
// step that clamps and interleaves, then a read and a write-back cycle on the
// cell store; the write-back waits while the output is held. A read command
// only reads and replies. The cell store is a single-port memory of
// 4^MAX_LEVELS entries; after reset a pass clears every presence bit, and no
// item is taken until it ends (configuration writes are taken throughout).
// Configuration is to be written only while idle; the block does not check.
module quadtree_cell_run_tracker_top #(
	parameter int MAX_LEVELS = qtcrt_pkg::MAX_LEVELS_DEF,
	parameter int INDEX_BITS = qtcrt_pkg::INDEX_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  qtcrt_pkg::in_item_t              in_item,
	output logic                             out_valid,
	input  wire                              out_ready,
	output qtcrt_pkg::out_item_t             out_item,
	input  wire                              cfg_we,
	input  wire [qtcrt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [qtcrt_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import qtcrt_pkg::*;

	localparam int LEAF_W = 2 * MAX_LEVELS;
	localparam int DEPTH  = 1 << LEAF_W;
	localparam int IW     = INDEX_BITS;
	localparam int SH_W   = 31 + MAX_LEVELS + 1;
	localparam int KW     = $clog2(MAX_LEVELS + 1);
	localparam int ENT_W  = 3 * IW;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_INIT  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_LEAF  = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_UPD   = 3'd6;

	// configuration
	logic [31:0] box_min_x_q, box_min_y_q, run_gap_limit_q;
	logic [30:0] leaf_size_q;
	logic [3:0]  tree_levels_q;

	logic [2:0]        state_q;
	logic [LEAF_W-1:0] clr_q;
	logic              cmd_q;
	logic [IW-1:0]     pnum_q;
	logic [32:0]       diff_q [2];
	logic [SH_W-1:0]   rem_q [2];
	logic [MAX_LEVELS-1:0] quo_q [2];
	logic              neg_q [2];
	logic              sat_q [2];
	logic [KW-1:0]     k_q;
	logic [LEAF_W-1:0] leaf_q;

	logic              used_mem [DEPTH];
	logic [ENT_W-1:0]  data_mem [DEPTH];
	logic              used_rd_q;
	logic [ENT_W-1:0]  data_rd_q;

	logic      out_valid_q;
	out_item_t out_item_q;

	logic [3:0]            lv;
	logic [30:0]           size_eff;
	logic [MAX_LEVELS-1:0] top;
	logic [MAX_LEVELS-1:0] axis_q [2];
	logic [LEAF_W-1:0]     leaf_calc;
	logic                  upd_go;

	assign lv       = (tree_levels_q > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : tree_levels_q;
	assign size_eff = (leaf_size_q == 31'd0) ? 31'd1 : leaf_size_q;
	assign top      = MAX_LEVELS'(((MAX_LEVELS + 1)'(1) << lv) - (MAX_LEVELS + 1)'(1));

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign upd_go    = (state_q == ST_UPD) && (!out_valid_q || out_ready);

	// clamp each axis to the square, then interleave with x in the low bit
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			if (neg_q[a]) begin
				axis_q[a] = '0;
			end else if (sat_q[a] || quo_q[a] > top) begin
				axis_q[a] = top;
			end else begin
				axis_q[a] = quo_q[a];
			end
		end
		for (int i = 0; i < MAX_LEVELS; i++) begin
			leaf_calc[2*i]   = axis_q[0][i];
			leaf_calc[2*i+1] = axis_q[1][i];
		end
	end

	// record update
	logic [IW-1:0] rd_cnt, rd_first, rd_last;
	logic [IW-1:0] new_cnt, new_first, new_last, cl_first, cl_last, gap;
	logic [1:0]    kind;
	logic          present;

	assign {rd_cnt, rd_first, rd_last} = data_rd_q;
	assign gap = pnum_q - rd_last;

	always_comb begin
		new_cnt   = rd_cnt;
		new_first = rd_first;
		new_last  = rd_last;
		cl_first  = '0;
		cl_last   = '0;
		present   = 1'b1;
		kind      = EV_NEW_CELL;
		if (cmd_q == CMD_READ) begin
			kind    = EV_READ_REPLY;
			present = used_rd_q;
			if (!used_rd_q) begin
				new_cnt   = '0;
				new_first = '0;
				new_last  = '0;
			end
		end else if (!used_rd_q) begin
			new_cnt   = IW'(1);
			new_first = pnum_q;
			new_last  = pnum_q;
		end else begin
			if (rd_cnt != '1) begin
				new_cnt = rd_cnt + IW'(1);
			end
			if (gap > IW'(run_gap_limit_q)) begin
				cl_first  = rd_first;
				cl_last   = rd_last;
				new_first = pnum_q;
				new_last  = pnum_q;
				kind      = EV_REOPENED;
			end else begin
				new_last = pnum_q;
				kind     = EV_EXTENDED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_x_q     <= RST_BOX_MIN_X;
			box_min_y_q     <= RST_BOX_MIN_Y;
			leaf_size_q     <= RST_LEAF_SIZE;
			tree_levels_q   <= RST_TREE_LEVELS;
			run_gap_limit_q <= RST_RUN_GAP_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_MIN_X:     box_min_x_q     <= cfg_data;
				REG_BOX_MIN_Y:     box_min_y_q     <= cfg_data;
				REG_LEAF_SIZE:     leaf_size_q     <= cfg_data[30:0];
				REG_TREE_LEVELS:   tree_levels_q   <= cfg_data[3:0];
				REG_RUN_GAP_LIMIT: run_gap_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + LEAF_W'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (in_item.command == CMD_READ) ? ST_READ : ST_INIT;
					end
				end
				ST_INIT: state_q <= ST_DIV;
				ST_DIV: begin
					if (k_q == '0) begin
						state_q <= ST_LEAF;
					end
				end
				ST_LEAF: state_q <= ST_READ;
				ST_READ: state_q <= ST_UPD;
				ST_UPD: begin
					if (upd_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q     <= in_item.command;
			pnum_q    <= IW'(in_item.point_number);
			leaf_q    <= LEAF_W'(in_item.leaf_select);
			diff_q[0] <= {in_item.coord_x[31], in_item.coord_x} -
				{box_min_x_q[31], box_min_x_q};
			diff_q[1] <= {in_item.coord_y[31], in_item.coord_y} -
				{box_min_y_q[31], box_min_y_q};
		end
		if (state_q == ST_INIT) begin
			k_q <= KW'(MAX_LEVELS - 1);
			for (int a = 0; a < 2; a++) begin
				neg_q[a] <= diff_q[a][32];
				rem_q[a] <= diff_q[a][32] ? '0 : SH_W'(diff_q[a]);
				sat_q[a] <= !diff_q[a][32] &&
					(SH_W'(diff_q[a]) >= (SH_W'(size_eff) << MAX_LEVELS));
				quo_q[a] <= '0;
			end
		end
		if (state_q == ST_DIV) begin
			k_q <= k_q - KW'(1);
			for (int a = 0; a < 2; a++) begin
				if (rem_q[a] >= (SH_W'(size_eff) << k_q)) begin
					rem_q[a] <= rem_q[a] - (SH_W'(size_eff) << k_q);
					quo_q[a] <= quo_q[a] | (MAX_LEVELS'(1) << k_q);
				end
			end
		end
		if (state_q == ST_LEAF) begin
			leaf_q <= leaf_calc;
		end
		if (upd_go) begin
			out_item_q.cell_number    <= depth_cell_base(lv) + 17'(leaf_q);
			out_item_q.event_kind     <= kind;
			out_item_q.cell_present   <= present;
			out_item_q.closed_start   <= 48'(cl_first);
			out_item_q.closed_end     <= 48'(cl_last);
			out_item_q.open_start     <= 48'(new_first);
			out_item_q.open_end       <= 48'(new_last);
			out_item_q.points_in_cell <= 48'(new_cnt);
		end
	end

	// cell store: presence bits and records
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			used_mem[clr_q] <= 1'b0;
		end else if (upd_go && cmd_q == CMD_ADD) begin
			used_mem[leaf_q] <= 1'b1;
		end
		if (state_q == ST_READ) begin
			used_rd_q <= used_mem[leaf_q];
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go && cmd_q == CMD_ADD) begin
			data_mem[leaf_q] <= {new_cnt, new_first, new_last};
		end
		if (state_q == ST_READ) begin
			data_rd_q <= data_mem[leaf_q];
		end
	end

endmodule
`default_nettype wire
